// ----- hw/rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier: register map,
// reset values, event codes, press state encoding and the configuration
// bundle handed from the register file to the classifier core.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // Register map: one 32-bit register every four bytes.
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;
   localparam int CsrIdxWidth  = 3;

   localparam logic [CsrIdxWidth-1:0] REG_PRESS_LEVEL  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_DEBOUNCE     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_LONG_PRESS   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_REPEAT       = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_SHORT_EN     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_LONG_EN      = 3'd5;

   // Reset values of the registers and of the filtered level.
   localparam logic        RST_PRESS_LEVEL  = 1'b0;
   localparam logic [7:0]  RST_DEBOUNCE     = 8'd3;
   localparam logic [15:0] RST_LONG_PRESS   = 16'd100;
   localparam logic [15:0] RST_REPEAT       = 16'd20;
   localparam logic        RST_SHORT_EN     = 1'b1;
   localparam logic        RST_LONG_EN      = 1'b1;
   localparam logic        RST_FILTERED     = 1'b1;

   // Event codes carried on the result channel.
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_SHORT  = 2'd1;
   localparam logic [1:0] EV_LONG   = 2'd2;
   localparam logic [1:0] EV_REPEAT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_PRESSED = 3'b010,
      ST_LONG    = 3'b100
   } press_state_type;

   typedef struct packed {
      logic        press_level;
      logic [7:0]  settle_ticks;
      logic [15:0] hold_ticks;
      logic [15:0] repeat_ticks;
      logic        short_enable;
      logic        long_enable;
   } cfg_type;

endpackage

// ----- hw/rtl/bpc_csr.sv -----
// ----------------------------------------------------------------------------
// bpc_csr
// Configuration register file on an APB-style port. Writes complete in the
// access cycle; reads return the register value, zero for unmapped slots.
// ----------------------------------------------------------------------------
module bpc_csr import bpc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [CsrIdxWidth-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CsrAddrWidth-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PRESS_LEVEL:  cfg_in.press_level      = csr_pwdata[0];
            REG_DEBOUNCE:     cfg_in.settle_ticks     = csr_pwdata[7:0];
            REG_LONG_PRESS:   cfg_in.hold_ticks       = csr_pwdata[15:0];
            REG_REPEAT:       cfg_in.repeat_ticks     = csr_pwdata[15:0];
            REG_SHORT_EN:     cfg_in.short_enable     = csr_pwdata[0];
            REG_LONG_EN:      cfg_in.long_enable      = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_level      <= RST_PRESS_LEVEL;
         cfg_ff.settle_ticks     <= RST_DEBOUNCE;
         cfg_ff.hold_ticks       <= RST_LONG_PRESS;
         cfg_ff.repeat_ticks     <= RST_REPEAT;
         cfg_ff.short_enable     <= RST_SHORT_EN;
         cfg_ff.long_enable      <= RST_LONG_EN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         REG_PRESS_LEVEL:  csr_prdata[0]    = cfg_ff.press_level;
         REG_DEBOUNCE:     csr_prdata[7:0]  = cfg_ff.settle_ticks;
         REG_LONG_PRESS:   csr_prdata[15:0] = cfg_ff.hold_ticks;
         REG_REPEAT:       csr_prdata[15:0] = cfg_ff.repeat_ticks;
         REG_SHORT_EN:     csr_prdata[0]    = cfg_ff.short_enable;
         REG_LONG_EN:      csr_prdata[0]    = cfg_ff.long_enable;
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/bpc_core.sv -----
// ----------------------------------------------------------------------------
// bpc_core
// Two-stage classifier pipeline: an input register holding the sampled pin
// level, then the debounce and press state update feeding a result register.
// ----------------------------------------------------------------------------
module bpc_core import bpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_pin_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_press_event,
   output logic       rsp_stable_level
);

   // Pipeline control
   logic            in_valid_ff;
   logic            in_pin_ff;
   logic            out_valid_ff;
   logic [1:0]      out_event_ff;
   logic            out_level_ff;
   logic            advance;
   logic            step;

   // Tick state
   logic            filt_ff;
   logic            filt_in;
   logic [7:0]      bounce_ff;
   logic [7:0]      bounce_in;
   logic [7:0]      bounce_inc;
   press_state_type state_ff;
   press_state_type state_in;
   logic [15:0]     held_ff;
   logic [15:0]     held_in;
   logic [15:0]     held_inc;
   logic [1:0]      event_in;
   logic            run;
   logic            pressed;

   // The result register frees up when it is empty or being taken.
   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign bounce_inc = bounce_ff + 8'd1;
   assign held_inc   = held_ff + 16'd1;

   always_comb begin
      filt_in   = filt_ff;
      bounce_in = 8'd0;
      run       = 1'b1;
      if (in_pin_ff != filt_ff) begin
         if (bounce_inc >= cfg.settle_ticks) begin
            filt_in = in_pin_ff;
         end else begin
            bounce_in = bounce_inc;
            run       = 1'b0;
         end
      end
   end

   assign pressed = (filt_in == cfg.press_level);

   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      event_in = EV_NONE;
      if (run) begin
         case (state_ff)
            ST_IDLE: begin
               if (pressed) begin
                  state_in = ST_PRESSED;
                  held_in  = 16'd0;
               end
            end
            ST_PRESSED: begin
               if (!pressed) begin
                  if (cfg.short_enable) event_in = EV_SHORT;
                  state_in = ST_IDLE;
               end else if (held_inc >= cfg.hold_ticks) begin
                  if (cfg.long_enable) event_in = EV_LONG;
                  held_in  = 16'd0;
                  state_in = ST_LONG;
               end else begin
                  held_in = held_inc;
               end
            end
            ST_LONG: begin
               if (!pressed) begin
                  state_in = ST_IDLE;
               end else if (held_inc >= cfg.repeat_ticks) begin
                  if (cfg.long_enable) event_in = EV_REPEAT;
                  held_in = 16'd0;
               end else begin
                  held_in = held_inc;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         filt_ff      <= RST_FILTERED;
         bounce_ff    <= 8'd0;
         state_ff     <= ST_IDLE;
         held_ff      <= 16'd0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) out_valid_ff <= in_valid_ff;
         if (step) begin
            filt_ff   <= filt_in;
            bounce_ff <= bounce_in;
            state_ff  <= state_in;
            held_ff   <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) in_pin_ff <= req_pin_level;
      if (step) begin
         out_event_ff <= event_in;
         out_level_ff <= filt_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_press_event  = out_event_ff;
   assign rsp_stable_level = out_level_ff;

   // While a level change is still pending the press machine must hold.
   a_pending_freezes: assert property (@(posedge clock) disable iff (reset)
      (step && bounce_in != 8'd0) |=> ($stable(state_ff) && $stable(held_ff)))
      else $error("press machine moved while a level change was pending");

   a_long_enters_held: assert property (@(posedge clock) disable iff (reset)
      (step && event_in == EV_LONG) |=> (state_ff == ST_LONG && held_ff == 16'd0))
      else $error("long press did not enter the long-held state");

   a_short_from_pressed: assert property (@(posedge clock) disable iff (reset)
      (step && event_in == EV_SHORT) |-> (state_ff == ST_PRESSED && cfg.short_enable))
      else $error("short press reported outside the pressed state");

   a_result_follows_step: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed transaction produced no result");

endmodule

// ----- hw/rtl/button_press_classifier.sv -----
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounced button classifier reporting short presses, long presses and
// auto-repeat events, one result transaction per pin-level tick.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/ready    req_pin_level
//   rsp      out        rsp_valid/ready    rsp_press_event, rsp_stable_level
//   csr      in/out     APB-style          paddr/pwdata/prdata, 6 registers
//
// One tick is taken every cycle while the result is not stalled; each tick
// passes through the input register, then the result register.
// The whole per-tick update is a single pass between those two registers.
// A stalled result holds the result register and, behind it, the input
// register; req_ready drops only when both are full.
// Synchronous reset restores the registers, clears the counters and returns
// the press machine to idle with the filtered level high.
// ----------------------------------------------------------------------------
module button_press_classifier import bpc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_pin_level,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_press_event,
   output logic                    rsp_stable_level,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type cfg;

   bpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bpc_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_press_event  (rsp_press_event),
      .rsp_stable_level (rsp_stable_level)
   );

endmodule
